[sv/awve_pkg.sv]
// Package for the adaptive window velocity estimator.
// Shared types and constants; no dependencies.
`default_nettype none
package awve_pkg;
  localparam int unsigned ScaleUs = 1000000;

  typedef enum logic {
    CMD_SAMPLE  = 1'b0,
    CMD_RESTART = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_STEP_THRESHOLD = 2'd0,
    REG_VELOCITY_LIMIT = 2'd1,
    REG_POSITION_LOWER = 2'd2,
    REG_POSITION_UPPER = 2'd3
  } reg_e;

  // Input request payload
  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] position;
    logic [31:0]        timestamp;
  } sample_t;

  // Result payload
  typedef struct packed {
    logic signed [31:0] velocity;
    logic [3:0]         window_used;
    logic               velocity_out_of_range;
    logic               position_out_of_range;
  } estimate_t;

  // Divider request from the history sequencer
  typedef struct packed {
    logic        neg;
    logic [51:0] dividend;
    logic [31:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

[sv/awve_if.sv]
// Valid/ready channel interface carrying a payload struct.
// Depends on nothing; the payload type is a parameter.
`default_nettype none
interface awve_if #(parameter type payload_t = logic) (input wire logic clk_i);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/awve_div.sv]
// Serial restoring divider, one quotient bit a cycle.
// Depends on awve_pkg.
`default_nettype none
module awve_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire awve_pkg::div_req_t  req_i,
  output logic                     done_o,
  output logic signed [31:0]       quot_o
);
  import awve_pkg::*;

  logic [51:0] rem_q, rem_d, quo_q, quo_d;
  logic [31:0] dvs_q;
  logic        neg_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_d, done_q;
  logic [52:0] trial;
  logic [52:0] shifted;

  // Shift one bit in and try a subtract
  always_comb begin
    shifted = {rem_q, quo_q[51]};
    trial   = shifted - {21'd0, dvs_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (busy_q) begin
      if (!trial[52]) begin
        rem_d = trial[51:0];
        quo_d = {quo_q[50:0], 1'b1};
      end else begin
        rem_d = shifted[51:0];
        quo_d = {quo_q[50:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= done_d;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd52;
      end else begin
        busy_q <= busy_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      neg_q <= req_i.neg;
    end else begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // Saturate the magnitude and apply the sign
  always_comb begin
    if (neg_q) begin
      if (quo_q > 52'h80000000) quot_o = 32'sh80000000;
      else quot_o = -$signed(quo_q[31:0]);
    end else begin
      if (quo_q > 52'h7fffffff) quot_o = 32'sh7fffffff;
      else quot_o = $signed(quo_q[31:0]);
    end
  end
  assign done_o = done_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_busy_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 6'd0) else $error("divider busy with zero count");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("divider failed to start");
endmodule
`default_nettype wire

[sv/awve_core.sv]
// History memory and window search sequencer for one axis.
// Depends on awve_pkg and awve_div.
`default_nettype none
module awve_core #(
  parameter int HistoryDepth = 10
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [15:0]        step_threshold_i,
  input  wire logic [30:0]        velocity_limit_i,
  input  wire logic signed [31:0] position_lower_i,
  input  wire logic signed [31:0] position_upper_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               in_cmd_i,
  input  wire logic signed [31:0] in_position_i,
  input  wire logic [31:0]        in_timestamp_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      out_velocity_o,
  output logic [3:0]              out_window_used_o,
  output logic                    out_velocity_out_of_range_o,
  output logic                    out_position_out_of_range_o
);
  import awve_pkg::*;

  localparam int AW = $clog2(HistoryDepth);
  localparam logic [AW-1:0] LastIdx = AW'(HistoryDepth - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;

  // Circular history: head points at the newest entry
  logic [63:0] mem [HistoryDepth];
  logic [63:0] rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [63:0]   wr_data;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] step_q, step_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          restart_q, restart_d;
  logic signed [31:0] p0_q, pos_q;
  logic [31:0]   t0_q;

  logic signed [32:0] dp;
  logic [32:0]   dmag;
  logic [31:0]   dt;
  logic          hit;
  logic          div_start, div_done;
  div_req_t      div_req;
  logic signed [31:0] quot;
  logic          pflag;

  logic signed [31:0] vel_q;
  logic [3:0]    win_q;
  logic          vflag_q, pflag_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  function automatic logic [AW-1:0] wrap_sub(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} - {1'b0, b};
    if (s[AW]) s = s + (AW+1)'(HistoryDepth);
    return s[AW-1:0];
  endfunction

  assign dp   = 33'(p0_q) - 33'($signed(rd_q[63:32]));
  assign dmag = dp[32] ? 33'(-dp) : 33'(dp);
  assign dt   = t0_q - rd_q[31:0];
  assign hit  = dmag > {17'd0, step_threshold_i};
  assign pflag = (in_position_i < position_lower_i) || (in_position_i > position_upper_i);
  assign rd_addr = wrap_sub(head_q, step_d);

  always_comb begin
    div_req.neg      = dp[32];
    div_req.dividend = 52'(dmag) * 52'(ScaleUs);
    div_req.divisor  = dt;
  end

  // Sequencer: clear after reset, write newest (or refill on restart), scan back-steps, divide, present
  always_comb begin
    state_d = state_q; head_d = head_q; step_d = step_q; clr_d = clr_q;
    restart_d = restart_q;
    wr_en = 1'b0; wr_addr = head_q; wr_data = {in_position_i, in_timestamp_i};
    div_start = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        // Zero the history, one entry a cycle
        wr_en = 1'b1; wr_addr = clr_q; wr_data = '0;
        clr_d = clr_q + AW'(1);
        if (clr_q == LastIdx) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i == CMD_RESTART) begin
            wr_en = 1'b1; wr_addr = '0; wr_data = {in_position_i, 32'd0};
            head_d = '0; clr_d = AW'(1); restart_d = 1'b1;
            state_d = (HistoryDepth > 1) ? S_SCAN : S_OUT;
          end else begin
            head_d = (head_q == LastIdx) ? '0 : head_q + AW'(1);
            wr_en = 1'b1; wr_addr = head_d;
            step_d = AW'(1); restart_d = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (restart_q) begin
          // Fill the rest of the history, one entry a cycle
          wr_en = 1'b1; wr_addr = clr_q; wr_data = {pos_q, 32'd0};
          clr_d = clr_q + AW'(1);
          if (clr_q == LastIdx) state_d = S_OUT;
        end else begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (hit || step_q == LastIdx) begin
          if (dt == 32'd0) state_d = S_OUT;
          else begin div_start = 1'b1; state_d = S_DIV; end
        end else begin
          step_d = step_q + AW'(1); state_d = S_SCAN;
        end
      end
      S_DIV: if (div_done) state_d = S_OUT;
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; head_q <= '0; step_q <= '0; clr_q <= '0;
      restart_q <= 1'b0;
    end else begin
      state_q <= state_d; head_q <= head_d; step_q <= step_d; clr_q <= clr_d;
      restart_q <= restart_d;
    end
  end

  // Capture newest sample and result fields
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      p0_q <= in_position_i; t0_q <= in_timestamp_i; pos_q <= in_position_i;
      pflag_q <= pflag; vel_q <= '0; vflag_q <= 1'b0; win_q <= '0;
    end
    if (state_q == S_EVAL && (hit || step_q == LastIdx)) begin
      win_q <= 4'(step_q);
      vel_q <= '0;
      vflag_q <= 1'b0;
    end
    if (state_q == S_DIV && div_done) begin
      vel_q <= quot;
      vflag_q <= (quot[31] ? 33'(-33'(quot)) : 33'(quot)) > {2'd0, velocity_limit_i};
    end
  end

  awve_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .req_i(div_req),
    .done_o(div_done), .quot_o(quot)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_velocity_o = vel_q;
  assign out_window_used_o = win_q;
  assign out_velocity_out_of_range_o = vflag_q;
  assign out_position_out_of_range_o = pflag_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("accept while result pending");
  a_restart_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && restart_q) |-> (win_q == 4'd0 && vel_q == 32'sd0))
    else $error("restart result not zero");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL |-> (step_q != '0 && step_q <= LastIdx))
    else $error("back-step out of range");
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> state_q == S_DIV) else $error("divide without wait");
endmodule
`default_nettype wire

[sv/adaptive_window_velocity_estimator_unit.sv]
// Adaptive window velocity estimator, one encoder axis.
// A request walks back through the history, each back-step read then evaluated, until the
// step threshold is passed or the oldest entry is reached, then runs the serial 52-bit
// divide unless the time difference is zero, then presents; a restart refills the history.
// One request at a time, the next taken in the cycle after the result leaves.
// Reset loads register defaults, then a pass zeroes the history.
`default_nettype none
module adaptive_window_velocity_estimator_unit #(
  parameter int HISTORY_DEPTH = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  awve_if.sink             in_if,
  awve_if.source           out_if
);
  import awve_pkg::*;

  logic [15:0] thr_q;
  logic [30:0] vlim_q;
  logic signed [31:0] plo_q, phi_q;
  logic [1:0] ridx;

  assign pready   = 1'b1;
  assign ridx     = paddr[3:2];

  // Register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 16'd100; vlim_q <= '0; plo_q <= '0; phi_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_e'(ridx))
        REG_STEP_THRESHOLD: thr_q  <= pwdata[15:0];
        REG_VELOCITY_LIMIT: vlim_q <= pwdata[30:0];
        REG_POSITION_LOWER: plo_q  <= pwdata;
        REG_POSITION_UPPER: phi_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(ridx))
      REG_STEP_THRESHOLD: prdata = {16'd0, thr_q};
      REG_VELOCITY_LIMIT: prdata = {1'b0, vlim_q};
      REG_POSITION_LOWER: prdata = plo_q;
      REG_POSITION_UPPER: prdata = phi_q;
      default: prdata = '0;
    endcase
  end

  awve_core #(.HistoryDepth(HISTORY_DEPTH)) u_core (
    .clk_i, .rst_ni,
    .step_threshold_i(thr_q), .velocity_limit_i(vlim_q),
    .position_lower_i(plo_q), .position_upper_i(phi_q),
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .in_cmd_i(in_if.data.cmd), .in_position_i(in_if.data.position),
    .in_timestamp_i(in_if.data.timestamp),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .out_velocity_o(out_if.data.velocity),
    .out_window_used_o(out_if.data.window_used),
    .out_velocity_out_of_range_o(out_if.data.velocity_out_of_range),
    .out_position_out_of_range_o(out_if.data.position_out_of_range)
  );
endmodule
`default_nettype wire

[verif/tb_adaptive_window_velocity_estimator_unit.sv]
// Testbench for the adaptive window velocity estimator unit.
// Depends on awve_pkg, awve_if and the unit; predicts each estimate and checks it.
`default_nettype none
module tb_adaptive_window_velocity_estimator_unit;
  import awve_pkg::*;

  localparam int Depth = 10;
  localparam int DrainCycles = 120;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  awve_if #(.payload_t(sample_t)) sample_if (clk_i);
  awve_if #(.payload_t(estimate_t)) estimate_if (clk_i);

  adaptive_window_velocity_estimator_unit #(.HISTORY_DEPTH(Depth)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_if  (sample_if),
    .out_if (estimate_if)
  );

  // Shadow copy of registers and sample history
  logic [15:0]        thr_q;
  logic [30:0]        vlim_q;
  logic signed [31:0] plo_q, phi_q;
  logic signed [31:0] pos_hist[Depth];
  logic [31:0]        ts_hist[Depth];

  estimate_t expected_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_restart = 0;
  int n_fallback = 0;
  bit no_idle = 0;
  int hold_request = 0;

  // Clock
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Compute the estimate for one sample and advance the history
  function automatic estimate_t estimate_velocity(sample_t s);
    estimate_t r;
    longint dp, d, q, mag;
    logic [31:0] dt;
    int sel;
    r = '0;
    if (s.cmd == CMD_RESTART) begin
      for (int i = 0; i < Depth; i++) begin
        pos_hist[i] = s.position;
        ts_hist[i] = '0;
      end
      n_restart++;
    end else begin
      for (int i = Depth - 1; i > 0; i--) begin
        pos_hist[i] = pos_hist[i-1];
        ts_hist[i] = ts_hist[i-1];
      end
      pos_hist[0] = s.position;
      ts_hist[0] = s.timestamp;
      sel = Depth - 1;
      for (int i = 1; i < Depth; i++) begin
        d = longint'(pos_hist[0]) - longint'(pos_hist[i]);
        if (d < 0) d = -d;
        if (d > longint'(thr_q)) begin
          sel = i;
          break;
        end
      end
      if (sel == Depth - 1) n_fallback++;
      dp = longint'(pos_hist[0]) - longint'(pos_hist[sel]);
      dt = ts_hist[0] - ts_hist[sel];
      q = 0;
      if (dt != 0) begin
        q = (dp * 1000000) / longint'({32'd0, dt});
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
      end
      mag = (q < 0) ? -q : q;
      r.velocity = q[31:0];
      r.window_used = sel[3:0];
      r.velocity_out_of_range = mag > longint'({33'd0, vlim_q});
    end
    r.position_out_of_range = (s.position < plo_q) || (s.position > phi_q);
    return r;
  endfunction

  // Send one request, honoring random idle gaps
  task automatic send_sample(cmd_e cmd, logic [31:0] pos, logic [31:0] ts);
    sample_t s;
    s.cmd = cmd;
    s.position = pos;
    s.timestamp = ts;
    while (!no_idle && $urandom_range(99) < 34) begin
      @(negedge clk_i);
      sample_if.valid = 1'b0;
    end
    @(negedge clk_i);
    sample_if.valid = 1'b1;
    sample_if.data = s;
    do @(posedge clk_i); while (!sample_if.ready);
    expected_q.push_back(estimate_velocity(s));
    n_sent++;
  endtask

  // Drop valid and wait until all estimates are back and the unit is quiet
  task automatic drain();
    @(negedge clk_i);
    sample_if.valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Register write: setup then access
  task automatic write_reg(reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_STEP_THRESHOLD: thr_q = value[15:0];
      REG_VELOCITY_LIMIT: vlim_q = value[30:0];
      REG_POSITION_LOWER: plo_q = value;
      REG_POSITION_UPPER: phi_q = value;
      default: ;
    endcase
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_config(logic [15:0] thr, logic [30:0] vlim, logic [31:0] lo,
                            logic [31:0] hi);
    drain();
    write_reg(REG_STEP_THRESHOLD, {16'd0, thr});
    write_reg(REG_VELOCITY_LIMIT, {1'b0, vlim});
    write_reg(REG_POSITION_LOWER, lo);
    write_reg(REG_POSITION_UPPER, hi);
  endtask

  // Restart then a run of samples with random steps and time gaps
  task automatic send_motion(int n, int max_step, int max_gap);
    logic [31:0] p, t;
    p = $urandom;
    t = $urandom;
    send_sample(CMD_RESTART, p, $urandom);
    for (int i = 0; i < n; i++) begin
      p = p + $urandom_range(2 * max_step) - max_step;
      t = t + (($urandom_range(19) == 0) ? 0 : $urandom_range(max_gap));
      send_sample(CMD_SAMPLE, p, t);
    end
  endtask

  // Result checker
  initial begin
    estimate_t exp_r, got;
    estimate_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (estimate_if.valid && estimate_if.ready) begin
        got = estimate_if.data;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected estimate %h", $time, got);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          n_checked++;
          if (got.velocity !== exp_r.velocity) begin
            $display("%0t: velocity expected %0d actual %0d", $time,
                     exp_r.velocity, got.velocity);
            errors++;
          end
          if (got.window_used !== exp_r.window_used) begin
            $display("%0t: window_used expected %0d actual %0d", $time,
                     exp_r.window_used, got.window_used);
            errors++;
          end
          if (got.velocity_out_of_range !== exp_r.velocity_out_of_range) begin
            $display("%0t: velocity_out_of_range expected %b actual %b", $time,
                     exp_r.velocity_out_of_range, got.velocity_out_of_range);
            errors++;
          end
          if (got.position_out_of_range !== exp_r.position_out_of_range) begin
            $display("%0t: position_out_of_range expected %b actual %b", $time,
                     exp_r.position_out_of_range, got.position_out_of_range);
            errors++;
          end
        end
      end
      @(negedge clk_i);
      // Hold off for a requested stretch, else idle at random
      if (hold_request > 0) begin
        estimate_if.ready = 1'b0;
        hold_request--;
      end else begin
        estimate_if.ready = no_idle || ($urandom_range(99) >= 34);
      end
    end
  end

  task automatic test_directed();
    set_config(16'd100, 31'd1000, 32'h8000_0000, 32'h7fff_ffff);
    send_sample(CMD_RESTART, 32'd0, 32'd0);
    send_sample(CMD_SAMPLE, 32'd50, 32'd1000);
    send_sample(CMD_SAMPLE, 32'd300, 32'd2000);
    send_sample(CMD_SAMPLE, 32'd300, 32'd2000);
    send_sample(CMD_SAMPLE, 32'h7fff_ffff, 32'd2001);
    send_sample(CMD_SAMPLE, 32'h8000_0000, 32'd2002);
    send_sample(CMD_SAMPLE, 32'h8000_0000, 32'hffff_ffff);
    send_sample(CMD_SAMPLE, 32'h7fff_ffff, 32'd5);
    send_sample(CMD_SAMPLE, 32'h7fff_ffff, 32'd5);
    send_sample(CMD_RESTART, 32'h8000_0000, 32'hffff_ffff);
    send_sample(CMD_SAMPLE, 32'h8000_0000, 32'd0);
    for (int i = 1; i <= 10; i++) send_sample(CMD_SAMPLE, 32'h8000_0000, i * 100);
    send_sample(CMD_SAMPLE, 32'h8000_0065, 32'd1200);
    // Inverted position limits, zero threshold and limit
    set_config(16'd0, 31'd0, 32'd10, -32'sd10);
    send_sample(CMD_RESTART, 32'd0, 32'd0);
    send_sample(CMD_SAMPLE, 32'd1, 32'd1);
    send_sample(CMD_SAMPLE, 32'd1, 32'd2);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(16'd100, 31'd50000, -32'sd100000, 32'sd100000);
        1: set_config(16'd0, 31'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        2: set_config(16'hffff, 31'd0, 32'sd0, 32'sd0);
        default: set_config(16'($urandom), 31'($urandom), $urandom, $urandom);
      endcase
      no_idle = (phase == 3);
      for (int k = 0; k < 14; k++) begin
        case ($urandom_range(3))
          0: send_motion($urandom_range(5, 25), 50, 3);
          1: send_motion($urandom_range(5, 25), 400, 2000);
          2: send_motion($urandom_range(5, 25), 70000, 100000);
          default: begin
            // Noise: arbitrary commands and values
            for (int i = 0; i < 10; i++)
              send_sample(($urandom_range(7) == 0) ? CMD_RESTART : CMD_SAMPLE,
                          $urandom, $urandom);
          end
        endcase
      end
      no_idle = 0;
    end
  endtask

  task automatic test_backpressure();
    set_config(16'd20, 31'd100000, -32'sd5000, 32'sd5000);
    hold_request = 400;
    send_motion(40, 100, 500);
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_if.valid = 1'b0;
    sample_if.data = '0;
    thr_q = 16'd100;
    vlim_q = '0;
    plo_q = '0;
    phi_q = '0;
    for (int i = 0; i < Depth; i++) begin
      pos_hist[i] = '0;
      ts_hist[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random();
    test_backpressure();
    drain();
    $display("Covered %0d requests (%0d restarts), %0d estimates checked, %0d fallbacks.",
             n_sent, n_restart, n_checked, n_fallback);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30000000;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
